// File: rtl/core/rsta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsta_pkg: shared types for the RPN stack ALU
// Token codes and the per-cell shift commands.
// ----------------------------------------------------------------------------
package rsta_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_SUB    = 3'd2,
        ACT_MUL    = 3'd3,
        ACT_FINISH = 3'd4
    } t_action;

    // LOAD_UP takes the entry from the cell nearer the top (push),
    // LOAD_DN takes it from the deeper cell (pop).
    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_LOAD_UP = 2'd1,
        CELL_LOAD_DN = 2'd2
    } t_cell_op;

endpackage

// File: rtl/core/rpn_stack_twos_complement_alu_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_twos_complement_alu_unit: reverse-Polish evaluator
// Stack of shifting cells with the top entry in cell 0, plus an ALU.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one token per transaction. s_tuser carries the action
//   (push, add, subtract, multiply, finish); s_tdata carries the operand.
//   Master channel: exactly one result transaction per token, in order.
//   m_tdata holds top value, its out-of-range mark, depth and the error flag;
//   m_tuser is set on the result of a finish token.
// Latency: the result is valid the cycle after the token is accepted.
// Throughput: one token per cycle while the receiver keeps taking results; the
//   stack cells and the output register update together when a token is accepted.
// Stall: a waiting result sits in the output register; a new token is taken
//   in the same cycle the receiver takes the result, otherwise s_tready drops.
// Reset: stack empty, malformed flag cleared, no result pending. The stack
//   cells themselves are not cleared; only entries below the depth are read.
// ----------------------------------------------------------------------------
module rpn_stack_twos_complement_alu_unit #(
    parameter int WORD_BITS   = 10,
    parameter int STACK_DEPTH = 16,
    localparam int DW     = $clog2(STACK_DEPTH + 1),
    localparam int IN_TDW = ((WORD_BITS + 7) / 8) * 8,
    localparam int OUT_W  = WORD_BITS + DW + 2,
    localparam int OUT_TDW = ((OUT_W + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [IN_TDW-1:0]  i_s_tdata,   // operand
    input  logic [2:0]         i_s_tuser,   // action
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [OUT_TDW-1:0] o_m_tdata,   // top_value, top_out_of_range, depth,
                                            // expression_error
    output logic               o_m_tuser    // finished
);
    import rsta_pkg::*;

    logic [DW-1:0]        r_ptr, n_ptr;
    logic                 r_mal, n_mal;
    logic                 r_m_valid;
    logic [WORD_BITS-1:0] r_top_val, n_top_val;
    logic                 r_top_mark, n_top_mark;
    logic [DW-1:0]        r_depth, n_depth;
    logic                 r_err, n_err;
    logic                 r_fin, n_fin;

    logic [WORD_BITS-1:0] w_val  [STACK_DEPTH];
    logic                 w_mark [STACK_DEPTH];
    t_cell_op             w_head_op, w_body_op;
    logic [WORD_BITS-1:0] w_head_val;
    logic                 w_head_mark;

    logic                 w_accept;
    t_action              w_act;
    logic [WORD_BITS-1:0] w_alu_res;
    logic                 w_alu_ovf;
    logic                 w_full, w_has1, w_has2;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_act    = t_action'(i_s_tuser);
    assign w_full   = (r_ptr == DW'(STACK_DEPTH));
    assign w_has1   = (r_ptr != '0);
    assign w_has2   = (r_ptr >= DW'(2));

    rsta_alu #(.WORD_BITS(WORD_BITS)) u_alu (
        .i_op  (w_act),
        .i_a   (w_val[1]),
        .i_b   (w_val[0]),
        .o_res (w_alu_res),
        .o_ovf (w_alu_ovf)
    );

    always_comb begin
        n_ptr       = r_ptr;
        n_mal       = r_mal;
        n_fin       = 1'b0;
        w_head_op   = CELL_HOLD;
        w_body_op   = CELL_HOLD;
        w_head_val  = i_s_tdata[WORD_BITS-1:0];
        w_head_mark = 1'b0;
        n_top_val   = w_has1 ? w_val[0] : '0;
        n_top_mark  = w_has1 ? w_mark[0] : 1'b0;
        case (w_act)
            ACT_PUSH: begin
                if (w_full) begin
                    n_mal = 1'b1;
                end else begin
                    w_head_op  = CELL_LOAD_UP;
                    w_body_op  = CELL_LOAD_UP;
                    n_ptr      = r_ptr + 1'b1;
                    n_top_val  = i_s_tdata[WORD_BITS-1:0];
                    n_top_mark = 1'b0;
                end
            end
            ACT_ADD, ACT_SUB, ACT_MUL: begin
                if (!w_has2) begin
                    n_mal = 1'b1;
                end else begin
                    w_head_op   = CELL_LOAD_UP;
                    w_body_op   = CELL_LOAD_DN;
                    w_head_val  = w_alu_res;
                    w_head_mark = w_mark[0] | w_mark[1] | w_alu_ovf;
                    n_ptr       = r_ptr - 1'b1;
                    n_top_val   = w_head_val;
                    n_top_mark  = w_head_mark;
                end
            end
            ACT_FINISH: begin
                n_ptr = '0;
                n_mal = 1'b0;
                n_fin = 1'b1;
            end
            default: begin
            end
        endcase
        n_depth = (w_act == ACT_FINISH) ? '0 : n_ptr;
        n_err   = (w_act == ACT_FINISH) ? (r_mal || (r_ptr != DW'(1))) : n_mal;
        if (!w_accept) begin
            w_head_op = CELL_HOLD;
            w_body_op = CELL_HOLD;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [WORD_BITS-1:0] w_up_val, w_dn_val;
            logic                 w_up_mark, w_dn_mark;
            t_cell_op             w_cell_op;
            if (gi == 0) begin : g_head
                assign w_up_val  = w_head_val;
                assign w_up_mark = w_head_mark;
                assign w_cell_op = w_head_op;
            end else begin : g_body
                assign w_up_val  = w_val[gi-1];
                assign w_up_mark = w_mark[gi-1];
                assign w_cell_op = w_body_op;
            end
            if (gi == STACK_DEPTH - 1) begin : g_last
                assign w_dn_val  = '0;
                assign w_dn_mark = 1'b0;
            end else begin : g_mid
                assign w_dn_val  = w_val[gi+1];
                assign w_dn_mark = w_mark[gi+1];
            end
            rsta_cell #(.WORD_BITS(WORD_BITS)) u_cell (
                .i_clk     (i_clk),
                .i_op      (w_cell_op),
                .i_up_val  (w_up_val),
                .i_up_mark (w_up_mark),
                .i_dn_val  (w_dn_val),
                .i_dn_mark (w_dn_mark),
                .o_val     (w_val[gi]),
                .o_mark    (w_mark[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_mal     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_ptr <= n_ptr;
                r_mal <= n_mal;
            end
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_top_val  <= n_top_val;
            r_top_mark <= n_top_mark;
            r_depth    <= n_depth;
            r_err      <= n_err;
            r_fin      <= n_fin;
        end
    end

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_TDW'({r_err, r_depth, r_top_mark, r_top_val});
    assign o_m_tuser  = r_fin;

endmodule

// File: rtl/core/rsta_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsta_cell: one stack entry
// Holds a word and its out-of-range mark; shifts toward or away from the top.
// ----------------------------------------------------------------------------
module rsta_cell #(
    parameter int WORD_BITS = 10
) (
    input  logic                  i_clk,
    input  rsta_pkg::t_cell_op    i_op,
    input  logic [WORD_BITS-1:0]  i_up_val,
    input  logic                  i_up_mark,
    input  logic [WORD_BITS-1:0]  i_dn_val,
    input  logic                  i_dn_mark,
    output logic [WORD_BITS-1:0]  o_val,
    output logic                  o_mark
);
    import rsta_pkg::*;

    logic [WORD_BITS-1:0] r_val;
    logic                 r_mark;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_LOAD_UP: begin
                r_val  <= i_up_val;
                r_mark <= i_up_mark;
            end
            CELL_LOAD_DN: begin
                r_val  <= i_dn_val;
                r_mark <= i_dn_mark;
            end
            default: begin
                r_val  <= r_val;
                r_mark <= r_mark;
            end
        endcase
    end

    assign o_val  = r_val;
    assign o_mark = r_mark;

endmodule

// File: rtl/core/rsta_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsta_alu: add / subtract / multiply on the two top entries
// Signed overflow for add and subtract; magnitude check for multiply.
// ----------------------------------------------------------------------------
module rsta_alu #(
    parameter int WORD_BITS = 10
) (
    input  rsta_pkg::t_action     i_op,
    input  logic [WORD_BITS-1:0]  i_a,
    input  logic [WORD_BITS-1:0]  i_b,
    output logic [WORD_BITS-1:0]  o_res,
    output logic                  o_ovf
);
    import rsta_pkg::*;

    logic [WORD_BITS:0]     w_sum;
    logic [WORD_BITS:0]     w_dif;
    logic [WORD_BITS-1:0]   w_mag_a;
    logic [WORD_BITS-1:0]   w_mag_b;
    logic [2*WORD_BITS-1:0] w_prod;
    logic [WORD_BITS-1:0]   w_prod_lo;
    logic                   w_neg;

    assign w_sum = {i_a[WORD_BITS-1], i_a} + {i_b[WORD_BITS-1], i_b};
    assign w_dif = {i_a[WORD_BITS-1], i_a} - {i_b[WORD_BITS-1], i_b};

    // most negative word negates to itself, which is its correct unsigned magnitude
    assign w_mag_a   = i_a[WORD_BITS-1] ? (~i_a + 1'b1) : i_a;
    assign w_mag_b   = i_b[WORD_BITS-1] ? (~i_b + 1'b1) : i_b;
    assign w_prod    = {{WORD_BITS{1'b0}}, w_mag_a} * {{WORD_BITS{1'b0}}, w_mag_b};
    assign w_prod_lo = w_prod[WORD_BITS-1:0];
    assign w_neg     = i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];

    always_comb begin
        case (i_op)
            ACT_ADD: begin
                o_res = w_sum[WORD_BITS-1:0];
                o_ovf = w_sum[WORD_BITS] ^ w_sum[WORD_BITS-1];
            end
            ACT_SUB: begin
                o_res = w_dif[WORD_BITS-1:0];
                o_ovf = w_dif[WORD_BITS] ^ w_dif[WORD_BITS-1];
            end
            ACT_MUL: begin
                o_res = w_neg ? (~w_prod_lo + 1'b1) : w_prod_lo;
                o_ovf = |w_prod[2*WORD_BITS-1:WORD_BITS-1];
            end
            default: begin
                o_res = '0;
                o_ovf = 1'b0;
            end
        endcase
    end

endmodule
